// ===== rtl/sensor_frame_parser_top_macros.svh =====
// Assertion macros for the sensor frame parser top level.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define SENSOR_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sensor_frame_parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sensor_frame_parser: next-cycle check failed");

`endif

// ===== rtl/sfp_pkg.sv =====
// Shared constants, types and character codes of the sensor frame parser.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package sfp_pkg;

  localparam int MAX_FRAME  = 100;
  localparam int CHANNELS   = 8;
  localparam int POS_W      = 7;
  localparam int FIELD_W    = 4;
  localparam int VAL_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_MODE  = 1'b1;

  // ASCII codes the parser looks for.
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_D      = 8'h44;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;

  // Digital frames carry channel i at byte position DIG_FIRST_POS + DIG_STRIDE * i.
  localparam int DIG_FIRST_POS = 6;
  localparam int DIG_STRIDE    = 5;

  localparam logic [BYTE_W-1:0] HASH_DIFF = CH_HASH - CH_ZERO;
  localparam logic [BYTE_W-1:0] NUL_DIFF  = 8'h00 - CH_ZERO;
  localparam logic [VAL_W-1:0]  VAL_AT_HASH = {{(VAL_W-BYTE_W){1'b0}}, HASH_DIFF};
  localparam logic [VAL_W-1:0]  VAL_BEYOND  = {{(VAL_W-BYTE_W){1'b0}}, NUL_DIFF};

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DIG  = 2'd1,
    KIND_ANA  = 2'd2
  } kind_e;

  typedef logic [CHANNELS-1:0][VAL_W-1:0] chan_vals_t;

  typedef struct packed {
    logic digital;
    logic analog;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic       is_analog;
    chan_vals_t vals;
  } emit_t;

endpackage

`default_nettype wire

// ===== rtl/sfp_if.sv =====
// Valid/ready channel interfaces for received bytes and channel results.
// Depends on sfp_pkg for the field widths.
`default_nettype none

interface sfp_in_if;
  import sfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_out_if;
  import sfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [VAL_W-1:0]  value;
  logic              is_analog;
  logic              last;
  modport source (output valid, output channel, output value, output is_analog,
                  output last, input ready);
  modport sink   (input valid, input channel, input value, input is_analog,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfp_in_reg.sv =====
// Input register of the sensor frame parser: holds one received byte.
// Depends on sfp_pkg and the sfp_in_if interface.
`default_nettype none

module sfp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sfp_in_if.sink                    rx_i,
  input  logic                      step_i,
  output logic                      valid_o,
  output logic [sfp_pkg::BYTE_W-1:0] byte_o
);
  import sfp_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              take;

  // The register frees up in the same cycle its byte is consumed.
  assign rx_i.ready = !valid_q || step_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== rtl/sfp_parser.sv =====
// Frame state and channel value accumulation of the sensor frame parser.
// Depends on sfp_pkg; computes the emission of a completing frame combinationally.
`default_nettype none

module sfp_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sfp_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  input  logic [sfp_pkg::BYTE_W-1:0] byte_i,
  input  logic                       step_i,
  output sfp_pkg::emit_t             emit_o
);
  import sfp_pkg::*;

  logic               in_frame_q, in_frame_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  kind_e              kind_q, kind_d;
  logic [FIELD_W-1:0] field_q, field_d;
  logic               colon_q, colon_d;
  logic               dend_q, dend_d;
  logic               dstart_q, dstart_d;
  logic               sep_q, sep_d;
  chan_vals_t         vals_q, vals_d;

  logic [BYTE_W-1:0]  diff;
  logic               is_digit;

  assign diff     = byte_i - CH_ZERO;
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);

  // Result of a '#' that closes the open frame.
  always_comb begin
    logic kind_ok;
    emit_o.is_analog = !cfg_i.digital;
    kind_ok = cfg_i.digital ? (kind_q == KIND_DIG) : (cfg_i.analog && kind_q == KIND_ANA);
    emit_o.emit = valid_i && in_frame_q && (byte_i == CH_HASH) && kind_ok;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!cfg_i.digital) begin
        emit_o.vals[i] = vals_q[i];
      end else if (POS_W'(DIG_FIRST_POS + DIG_STRIDE * i) < pos_q) begin
        emit_o.vals[i] = vals_q[i];
      end else if (POS_W'(DIG_FIRST_POS + DIG_STRIDE * i) == pos_q) begin
        emit_o.vals[i] = VAL_AT_HASH;
      end else begin
        emit_o.vals[i] = VAL_BEYOND;
      end
    end
  end

  always_comb begin
    kind_e            kind_n;
    logic [POS_W:0]   pos_inc;
    logic [FIELD_W-1:0] fld;
    logic             col, den, dst;
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    kind_d     = kind_q;
    field_d    = field_q;
    colon_d    = colon_q;
    dend_d     = dend_q;
    dstart_d   = dstart_q;
    sep_d      = sep_q;
    vals_d     = vals_q;
    kind_n     = kind_q;
    pos_inc    = {1'b0, pos_q} + (POS_W+1)'(1);
    fld        = field_q;
    col        = colon_q;
    den        = dend_q;
    dst        = dstart_q;

    if (step_i) begin
      if (byte_i == CH_DOLLAR) begin
        in_frame_d = 1'b1;
        pos_d      = POS_W'(1);
        kind_d     = KIND_NONE;
        field_d    = '0;
        colon_d    = 1'b0;
        dend_d     = 1'b0;
        dstart_d   = 1'b0;
        sep_d      = 1'b0;
        vals_d     = '0;
      end else if (in_frame_q && byte_i == CH_HASH) begin
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else if (in_frame_q) begin
        if (pos_q == POS_W'(1)) begin
          if (byte_i == CH_D) begin
            kind_n = KIND_DIG;
          end else if (byte_i == CH_A) begin
            kind_n = KIND_ANA;
          end else begin
            kind_n = KIND_NONE;
          end
        end
        kind_d = kind_n;

        case (kind_n)
          KIND_DIG: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (pos_q == POS_W'(DIG_FIRST_POS + DIG_STRIDE * i)) begin
                vals_d[i] = {{(VAL_W-BYTE_W){1'b0}}, diff};
              end
            end
          end
          KIND_ANA: begin
            if (byte_i == CH_COMMA || byte_i == CH_SPACE) begin
              sep_d = 1'b1;
            end else begin
              // A run of separators closes the field: open the next one.
              if (sep_q) begin
                if (field_q != {FIELD_W{1'b1}}) begin
                  fld = field_q + FIELD_W'(1);
                end
                col = 1'b0;
                den = 1'b0;
                dst = 1'b0;
              end
              sep_d = 1'b0;
              if (fld >= FIELD_W'(1) && fld <= FIELD_W'(CHANNELS)) begin
                if (!col) begin
                  if (byte_i == CH_COLON) begin
                    col = 1'b1;
                  end
                end else if (!den) begin
                  if (is_digit) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                      if (fld == FIELD_W'(i + 1)) begin
                        vals_d[i] = (vals_q[i] << 3) + (vals_q[i] << 1)
                                  + {{(VAL_W-4){1'b0}}, diff[3:0]};
                      end
                    end
                    dst = 1'b1;
                  end else if ((byte_i == CH_PLUS || byte_i == CH_MINUS) && !dst) begin
                    // Signs ahead of the first digit are skipped.
                  end else begin
                    den = 1'b1;
                  end
                end
              end
              field_d  = fld;
              colon_d  = col;
              dend_d   = den;
              dstart_d = dst;
            end
          end
          default: begin
          end
        endcase

        if (pos_inc >= (POS_W+1)'(MAX_FRAME)) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      kind_q     <= KIND_NONE;
      field_q    <= '0;
      colon_q    <= 1'b0;
      dend_q     <= 1'b0;
      dstart_q   <= 1'b0;
      sep_q      <= 1'b0;
      vals_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      field_q    <= field_d;
      colon_q    <= colon_d;
      dend_q     <= dend_d;
      dstart_q   <= dstart_d;
      sep_q      <= sep_d;
      vals_q     <= vals_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfp_out_seq.sv =====
// Result register and burst sequencer: sends one frame's channel values in order.
// Depends on sfp_pkg and the sfp_out_if interface.
`default_nettype none

module sfp_out_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sfp_pkg::emit_t emit_i,
  output logic           load_ok_o,
  sfp_out_if.source      res_o
);
  import sfp_pkg::*;

  chan_vals_t        snap_q, snap_d;
  logic              ana_q;
  logic              busy_q, busy_d;
  logic [CHAN_W-1:0] idx_q, idx_d;
  logic              is_last;
  logic              xfer;

  assign is_last   = (idx_q == CHAN_W'(CHANNELS - 1));
  assign xfer      = res_o.valid && res_o.ready;
  assign load_ok_o = !busy_q || (xfer && is_last);

  assign res_o.valid     = busy_q;
  assign res_o.channel   = idx_q;
  assign res_o.value     = snap_q[0];
  assign res_o.is_analog = ana_q;
  assign res_o.last      = is_last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    snap_d = snap_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      snap_d = emit_i.vals;
    end else if (xfer) begin
      busy_d = !is_last;
      idx_d  = idx_q + CHAN_W'(1);
      // Shift the next channel into the head slot.
      for (int i = 0; i < CHANNELS - 1; i++) begin
        snap_d[i] = snap_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    if (load_i) begin
      ana_q <= emit_i.is_analog;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sensor_frame_parser_top.sv =====
// Sensor frame parser: top level that ties input register, parser and result sequencer.
// Depends on sfp_pkg, sfp_if, sfp_in_reg, sfp_parser, sfp_out_seq and the macros header.
//
// The block takes one received ASCII byte per transfer on rx_i and assembles frames
// that open with '$' and close with '#'; a '$' inside a frame restarts it, and a frame
// that reaches MAX_FRAME bytes without '#' is dropped. When a frame closes and its
// kind (byte 1, 'D' or 'A') matches the configured mode, the block sends eight result
// transfers on res_o, channel 0 first, with last set on channel 7. Digital mode takes
// priority over analog mode. Each byte passes an input register before it is folded
// into the parser state, so bytes are taken one per cycle unless a closing byte is
// held back. A completed frame's values are copied into the result register, which
// drains one channel per output transfer; the byte that closes the next frame waits
// in the input register until the last result of the previous frame is transferred,
// so faster frames back-pressure rx_i. Configuration writes take effect at the clock
// edge at which cfg_we_i is high, and should only be issued while the block is idle.
`default_nettype none

`include "sensor_frame_parser_top_macros.svh"

module sensor_frame_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sfp_in_if.sink                         rx_i,
  sfp_out_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfp_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sfp_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_val;
  emit_t             emit;
  logic              load_ok;
  logic              step;
  logic              load;

  // Mode registers. Only bit 0 of the write data matters.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIGITAL_MODE: cfg_d.digital = cfg_wdata_i[0];
        CFG_ANALOG_MODE:  cfg_d.analog  = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{digital: 1'b1, analog: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A buffered byte is consumed unless it closes a frame with results while the
  // result register still holds an earlier frame.
  assign step = byte_valid && (!emit.emit || load_ok);
  assign load = step && emit.emit;

  sfp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .step_i  (step),
    .valid_o (byte_valid),
    .byte_o  (byte_val)
  );

  sfp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (byte_valid),
    .byte_i  (byte_val),
    .step_i  (step),
    .emit_o  (emit)
  );

  sfp_out_seq u_out_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .emit_i    (emit),
    .load_ok_o (load_ok),
    .res_o     (res_o)
  );

  // A new frame is loaded only when the previous burst is finished or ending now.
  `SFP_ASSERT_IMP(a_load_no_overwrite, load, !res_o.valid || (res_o.ready && res_o.last))
  // A burst continues after every transfer that is not the last one.
  `SFP_ASSERT_NXT(a_burst_continues, res_o.valid && res_o.ready && !res_o.last, res_o.valid)
  // The last flag is only set on the final channel.
  `SFP_ASSERT_IMP(a_last_channel, res_o.valid && res_o.last,
                  res_o.channel == CHAN_W'(CHANNELS - 1))

endmodule

`default_nettype wire

// ===== tb/sv/sfp_frame_checker.sv =====
// Result checker for the sensor frame parser: tracks byte and config transfers, predicts
// the channel results of each closed frame and compares them with the result channel.
// Depends on sfp_pkg and the sfp_in_if / sfp_out_if interfaces.

module sfp_frame_checker
  import sfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfp_in_if                     rx_mon,
  sfp_out_if                    res_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
    logic              is_analog;
    logic              last;
  } chan_result_t;

  chan_result_t pending_channels[$];

  // Mirror of the parser state.
  logic               dig_mode;
  logic               ana_mode;
  logic               frame_open;
  logic [POS_W-1:0]   byte_pos;
  kind_e              kind;
  logic [FIELD_W-1:0] field_idx;
  logic               after_colon;
  logic               digits_ended;
  logic               digits_started;
  logic               sep_pending;
  logic [VAL_W-1:0]   chan_vals[CHANNELS];

  int fails;
  int checked_n;

  function automatic void clear_frame_state();
    int i;
    kind           = KIND_NONE;
    field_idx      = '0;
    after_colon    = 1'b0;
    digits_ended   = 1'b0;
    digits_started = 1'b0;
    sep_pending    = 1'b0;
    for (i = 0; i < CHANNELS; i++) chan_vals[i] = '0;
  endfunction

  // Analog body: fields split on runs of commas or spaces, digits after the first colon.
  function automatic void parse_analog_byte(input logic [BYTE_W-1:0] b);
    int slot;
    if (b == CH_COMMA || b == CH_SPACE) begin
      sep_pending = 1'b1;
      return;
    end
    if (sep_pending) begin
      sep_pending = 1'b0;
      if (field_idx < 15) field_idx = field_idx + 1'b1;
      after_colon    = 1'b0;
      digits_ended   = 1'b0;
      digits_started = 1'b0;
    end
    if (field_idx < 1 || field_idx > CHANNELS) return;
    slot = int'(field_idx) - 1;
    if (!after_colon) begin
      if (b == CH_COLON) after_colon = 1'b1;
      return;
    end
    if (digits_ended) return;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      chan_vals[slot] = chan_vals[slot] * 16'd10 + {8'h00, b - CH_ZERO};
      digits_started  = 1'b1;
    end else if (!((b == CH_PLUS || b == CH_MINUS) && !digits_started)) begin
      digits_ended = 1'b1;
    end
  endfunction

  // Folds one received byte into the mirrored state; a closing byte may queue results.
  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    int           p;
    int           i;
    int           k;
    logic         dig;
    logic         emit;
    chan_result_t r;
    if (b == CH_DOLLAR) begin
      clear_frame_state();
      frame_open = 1'b1;
      byte_pos   = POS_W'(1);
      return;
    end
    if (!frame_open) return;
    p = int'(byte_pos);
    if (b == CH_HASH) begin
      dig        = dig_mode;
      emit       = dig ? (kind == KIND_DIG) : (ana_mode && kind == KIND_ANA);
      frame_open = 1'b0;
      byte_pos   = '0;
      if (!emit) return;
      for (i = 0; i < CHANNELS; i++) begin
        r.channel   = CHAN_W'(i);
        r.is_analog = !dig;
        r.last      = (i == CHANNELS - 1);
        if (!dig) begin
          r.value = chan_vals[i];
        end else if (DIG_FIRST_POS + DIG_STRIDE * i < p) begin
          r.value = chan_vals[i];
        end else if (DIG_FIRST_POS + DIG_STRIDE * i == p) begin
          r.value = {8'h00, CH_HASH - CH_ZERO};
        end else begin
          r.value = {8'h00, 8'h00 - CH_ZERO};
        end
        pending_channels.push_back(r);
      end
      return;
    end
    if (p == 1) begin
      if (b == CH_D) kind = KIND_DIG;
      else if (b == CH_A) kind = KIND_ANA;
      else kind = KIND_NONE;
    end
    if (kind == KIND_DIG) begin
      if (p >= DIG_FIRST_POS && (p - DIG_FIRST_POS) % DIG_STRIDE == 0) begin
        k = (p - DIG_FIRST_POS) / DIG_STRIDE;
        if (k < CHANNELS) chan_vals[k] = {8'h00, b - CH_ZERO};
      end
    end else if (kind == KIND_ANA) begin
      parse_analog_byte(b);
    end
    if (p + 1 >= MAX_FRAME) begin
      frame_open = 1'b0;
      byte_pos   = '0;
    end else begin
      byte_pos = POS_W'(p + 1);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_channel_result();
    chan_result_t want;
    if (pending_channels.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual channel %0d value %0d",
               $time, res_mon.channel, res_mon.value);
      fails++;
      return;
    end
    want = pending_channels.pop_front();
    checked_n++;
    compare_field("channel", VAL_W'(want.channel), VAL_W'(res_mon.channel));
    compare_field("value", want.value, res_mon.value);
    compare_field("is_analog", VAL_W'(want.is_analog), VAL_W'(res_mon.is_analog));
    compare_field("last", VAL_W'(want.last), VAL_W'(res_mon.last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame_state();
      dig_mode   = 1'b1;
      ana_mode   = 1'b0;
      frame_open = 1'b0;
      byte_pos   = '0;
      fails      = 0;
      checked_n  = 0;
      pending_channels.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DIGITAL_MODE) dig_mode = cfg_wdata_i[0];
        else if (cfg_idx_i == CFG_ANALOG_MODE) ana_mode = cfg_wdata_i[0];
      end
      if (rx_mon.valid && rx_mon.ready) decode_rx_byte(rx_mon.rx_byte);
      if (res_mon.valid && res_mon.ready) check_channel_result();
      fail_count_o <= fails;
      pending_o    <= pending_channels.size();
      checked_o    <= checked_n;
    end
  end

endmodule

// ===== tb/sv/tb_sensor_frame_parser_top.sv =====
// Testbench top for the sensor frame parser: clock, reset, byte stimulus, output
// back-pressure and the final verdict. Depends on sfp_pkg, the sfp interfaces,
// sfp_frame_checker and the sensor_frame_parser_top RTL.

module tb_sensor_frame_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfp_pkg::*;

  // Cycles the output side is held off in one piece to make the block back up.
  localparam int HOLD_CYCLES   = 250;
  // Quiet cycles after the last expected result; covers the input register, the
  // parser stage and the result register, with margin.
  localparam int SETTLE_CYCLES = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int bytes_sent;
  bit tx_idle_en;
  bit hold_req;

  sfp_in_if  rx_if();
  sfp_out_if res_if();

  sensor_frame_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  sfp_frame_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_mon       (rx_if),
    .res_mon      (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A byte that neither opens nor closes a frame, mostly printable.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(32, 126));
      else b = 8'($urandom_range(0, 255));
    end while (b == CH_DOLLAR || b == CH_HASH);
    return b;
  endfunction

  // Filler inside a frame; a small share is an arbitrary byte, so a stray '$'
  // restarts the frame or a stray '#' closes it early.
  function automatic logic [7:0] frame_byte();
    if ($urandom_range(0, 99) < 3) return 8'($urandom_range(0, 255));
    return body_byte();
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // One byte transfer. Valid stays high straight into the next byte when no gap
  // is drawn, so each step sees at most one assignment to it.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Stops the byte stream and waits until every predicted result has been
  // transferred, then lets the pipeline settle. The first edge makes sure the
  // checker has seen the last byte transfer before its pending count is trusted.
  task automatic drain();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both mode registers are written back to back, one per edge.
  task automatic set_modes(input logic dig, input logic ana);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DIGITAL_MODE;
    cfg_wdata <= dig;
    @(posedge clk);
    cfg_idx   <= CFG_ANALOG_MODE;
    cfg_wdata <= ana;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random sequence: mostly well-formed digital or analog frames with random
  // content, plus frames that run into the length limit and loose noise bytes.
  task automatic send_random_sequence();
    int r;
    int len;
    int pos;
    int fill;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // Digital frame; mostly short, so only the first channels are captured
      // and the rest read as the '#' or beyond-the-end values.
      len = ($urandom_range(0, 4) != 0) ? $urandom_range(3, 22) : $urandom_range(23, 48);
      put_byte(CH_DOLLAR);
      put_byte(CH_D);
      for (pos = 2; pos < len; pos++) begin
        if (pos >= DIG_FIRST_POS && (pos - DIG_FIRST_POS) % DIG_STRIDE == 0 &&
            $urandom_range(0, 4) != 0) begin
          put_byte(digit_byte());
        end else begin
          put_byte(frame_byte());
        end
      end
      put_byte(CH_HASH);
    end else if (r < 75) begin
      // Analog frame: separator runs, optional colon, signs and up to five
      // digits, which can overflow the 16-bit value.
      put_byte(CH_DOLLAR);
      put_byte(CH_A);
      repeat ($urandom_range(0, 2)) put_byte(frame_byte());
      repeat ($urandom_range(0, 9)) begin
        repeat ($urandom_range(1, 2)) put_byte($urandom_range(0, 1) ? CH_COMMA : CH_SPACE);
        if ($urandom_range(0, 4) == 0) put_byte(frame_byte());
        if ($urandom_range(0, 6) != 0) put_byte(CH_COLON);
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
          put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        end
        repeat ($urandom_range(0, 5)) put_byte(digit_byte());
        if ($urandom_range(0, 4) == 0) put_byte(frame_byte());
      end
      put_byte(CH_HASH);
    end else if (r < 87) begin
      // Long frame right at the length limit: with the longest fills the frame
      // is dropped and the closing '#' arrives outside any frame.
      put_byte(CH_DOLLAR);
      case ($urandom_range(0, 2))
        0:       put_byte(CH_D);
        1:       put_byte(CH_A);
        default: put_byte(body_byte());
      endcase
      fill = $urandom_range(96, 99);
      repeat (fill) put_byte(body_byte());
      put_byte(CH_HASH);
    end else begin
      repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stalls of varied length between runs of ready, and on
  // request one long hold-off counted here.
  initial begin
    int gap;
    int run;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [1:0] mode_table[4];
    int         phases;
    // {digital_mode, analog_mode} per random phase; all four combinations.
    mode_table = '{2'b10, 2'b01, 2'b11, 2'b00};
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_DIGITAL_MODE;
    cfg_wdata     <= '0;
    tx_idle_en = 1'b1;
    hold_req   = 1'b0;
    bytes_sent = 0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, digital mode. The second '$' restarts the frame; channel 0
    // is captured, the '#' lands on channel 1's position and the rest lie beyond.
    set_modes(1'b1, 1'b0);
    put_text("$D$Dabcd12345#");
    drain();

    // Analog mode: signs are skipped, a double space is one separator, a field
    // without a colon reads zero, a zero byte ends the digits, and the remaining
    // channels are missing. A digital frame then gets no results, and a stray
    // all-ones byte outside any frame is ignored.
    set_modes(1'b0, 1'b1);
    put_text("$A,:+12  :-3,9,:4");
    put_byte(8'h00);
    put_text("6#");
    put_text("$D#");
    put_byte(8'hFF);
    drain();

    // Back-pressure: the result side holds off while short frames keep coming,
    // so the result register fills and the byte input stalls. The bytes start
    // only once the hold-off is in force.
    set_modes(1'b1, 1'b0);
    hold_req = 1'b1;
    wait (!hold_req);
    repeat (5) put_text("$D7#");
    drain();

    // Random part, one sequence per phase, cycling through the mode settings until
    // each has been used and the byte budget is spent, for at most 32 phases; each
    // phase ends with a full drain so the next configuration write happens while idle.
    phases = 0;
    while (phases < 4 || (bytes_sent < 130 && phases < 32)) begin
      set_modes(mode_table[phases % 4][1], mode_table[phases % 4][0]);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      send_random_sequence();
      drain();
      phases++;
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d byte transfers and %0d checked channel results,",
             bytes_sent, checked);
    $display("with all four mode settings, one long output hold-off and %0d random phases.",
             phases);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard limit on run time, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sensor_frame_parser_top.f =====
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_if.sv
rtl/sfp_in_reg.sv
rtl/sfp_parser.sv
rtl/sfp_out_seq.sv
rtl/sensor_frame_parser_top.sv
tb/sv/sfp_frame_checker.sv
tb/sv/tb_sensor_frame_parser_top.sv
